### rtl/zst_pkg.sv
// Shared types and constants for the Zhang-Suen thinning sub-pass block.
// Used by the kernel and the top level; depends on nothing else.
package zst_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int DIM_W      = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBPASS_SELECT = 2'd2;

    localparam logic [DIM_W-1:0] DIM_RESET = 11'd1024;
    localparam logic [DIM_W-1:0] DIM_MIN   = 11'd3;

    localparam logic [3:0] MIN_NEIGHBORS = 4'd2;
    localparam logic [3:0] MAX_NEIGHBORS = 4'd6;

    localparam logic SUBPASS_FIRST  = 1'b0;
    localparam logic SUBPASS_SECOND = 1'b1;

    typedef struct packed {
        logic keep;
        logic del;
    } zst_verdict_t;

endpackage

### rtl/zhang_suen_thinning_pass_top.sv
// Top level of the Zhang-Suen thinning sub-pass: counters, window, line store, result register.
// Depends on zst_pkg, zst_line_store and zst_kernel.
//
// The block takes a binary image one pixel per beat in raster order and runs one
// Zhang-Suen sub-pass (first or second, chosen by subpass_select) over it. It accepts one
// pixel every clock cycle when the output side is not stalled. The result for an interior
// pixel appears in the output register the cycle after the pixel below and to its right is
// accepted; border pixels give no result. The line store is a single-port-write, registered-read
// memory whose next address is fetched ahead, which is what allows one pixel per cycle. The line
// store has no clearing pass after reset: the first two rows of a frame fill it before any result
// uses it. Configuration must be written only while the block is idle; this is not enforced.
module zhang_suen_thinning_pass_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [zst_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [zst_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          pixel_in,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          pixel_out,
    output logic                          removed,
    output logic                          frame_last,
    output logic                          any_removed
);
    import zst_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [DIM_W-1:0] image_width_reg;
    logic [DIM_W-1:0] image_height_reg;
    logic             subpass_reg;

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [8:0]    window_reg, window_next;
    logic          removal_seen_reg, removal_seen_next;

    logic          out_valid_reg;
    logic          pixel_out_reg, removed_reg, frame_last_reg, any_removed_reg;

    logic [CW-1:0] last_col;
    logic [RW-1:0] last_row;
    logic          row_end, frame_end, interior, in_accept;
    logic [CW-1:0] col_step, rd_addr;
    logic [1:0]    store_rd, store_wr;
    logic          above, two;
    zst_verdict_t  verdict;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= DIM_RESET;
            image_height_reg <= DIM_RESET;
            subpass_reg      <= SUBPASS_FIRST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:    image_width_reg  <= cfg_data;
                CFG_IMAGE_HEIGHT:   image_height_reg <= cfg_data;
                CFG_SUBPASS_SELECT: subpass_reg      <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        if (image_width_reg < DIM_MIN)
            last_col = CW'(2);
        else if (32'(image_width_reg) > MAX_WIDTH)
            last_col = CW'(MAX_WIDTH - 1);
        else
            last_col = CW'(image_width_reg - DIM_W'(1));

        if (image_height_reg < DIM_MIN)
            last_row = RW'(2);
        else if (32'(image_height_reg) > MAX_HEIGHT)
            last_row = RW'(MAX_HEIGHT - 1);
        else
            last_row = RW'(image_height_reg - DIM_W'(1));
    end

    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    assign row_end   = col_reg >= last_col;
    assign frame_end = row_end && (row_reg >= last_row);
    assign interior  = (row_reg >= RW'(2)) && (col_reg >= CW'(2));
    assign col_step  = row_end ? '0 : col_reg + CW'(1);
    assign rd_addr   = in_accept ? col_step : col_reg;

    assign above    = store_rd[0];
    assign two      = store_rd[1];
    assign store_wr = {above, pixel_in};

    zst_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW),
        .DW    (2)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (in_accept),
        .wr_addr (col_reg),
        .wr_data (store_wr),
        .rd_addr (rd_addr),
        .rd_data (store_rd)
    );

    assign window_next = {pixel_in, window_reg[8:7], above, window_reg[5:4], two,
                          window_reg[2:1]};

    zst_kernel u_kernel (
        .window  (window_next),
        .subpass (subpass_reg),
        .verdict (verdict)
    );

    always_comb
    begin
        removal_seen_next = removal_seen_reg | (interior & verdict.del);
        if (row_end)
        begin
            col_next = '0;
            row_next = frame_end ? '0 : row_reg + RW'(1);
        end
        else
        begin
            col_next = col_step;
            row_next = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg          <= '0;
            row_reg          <= '0;
            window_reg       <= '0;
            removal_seen_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            col_reg          <= col_next;
            row_reg          <= row_next;
            window_reg       <= window_next;
            removal_seen_reg <= frame_end ? 1'b0 : removal_seen_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= interior;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && interior)
        begin
            pixel_out_reg   <= verdict.keep;
            removed_reg     <= verdict.del;
            frame_last_reg  <= frame_end;
            any_removed_reg <= frame_end & removal_seen_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_out   = pixel_out_reg;
    assign removed     = removed_reg;
    assign frame_last  = frame_last_reg;
    assign any_removed = any_removed_reg;

    a_removed_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && removed_reg |-> !pixel_out_reg)
        else $error("Removed pixel is not reported as cleared.");

    a_any_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && any_removed_reg |-> frame_last_reg)
        else $error("any_removed set on a beat that does not end the frame.");

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && frame_end |=> col_reg == '0 && row_reg == '0 && !removal_seen_reg)
        else $error("Counters did not restart after the last pixel of a frame.");

    a_removal_tracked: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && interior && verdict.del && !frame_end |=> removal_seen_reg)
        else $error("A removal was not recorded for the frame summary.");

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg)
        else $error("Stalled result was dropped.");

endmodule

### rtl/zst_line_store.sv
// Two-row line store: one write port and one registered read port.
// Each entry holds the pixel one row above and the pixel two rows above.
module zst_line_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 2
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/zst_kernel.sv
// Zhang-Suen deletion test on one 3x3 window.
// Depends on zst_pkg for the verdict type and neighbor limits.
module zst_kernel (
    input  logic [8:0]          window,
    input  logic                subpass,
    output zst_pkg::zst_verdict_t verdict
);
    import zst_pkg::*;

    logic       p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [7:0] rising;
    logic [3:0] trans_cnt;
    logic [3:0] nbr_cnt;
    logic       m1, m2;
    logic       del;

    always_comb
    begin
        p1 = window[4];
        p2 = window[1];
        p3 = window[2];
        p4 = window[5];
        p5 = window[8];
        p6 = window[7];
        p7 = window[6];
        p8 = window[3];
        p9 = window[0];

        rising = {!p9 && p2, !p8 && p9, !p7 && p8, !p6 && p7,
                  !p5 && p6, !p4 && p5, !p3 && p4, !p2 && p3};
        trans_cnt = 4'({3'd0, rising[0]}) + 4'({3'd0, rising[1]}) +
                    4'({3'd0, rising[2]}) + 4'({3'd0, rising[3]}) +
                    4'({3'd0, rising[4]}) + 4'({3'd0, rising[5]}) +
                    4'({3'd0, rising[6]}) + 4'({3'd0, rising[7]});
        nbr_cnt = 4'({3'd0, p2}) + 4'({3'd0, p3}) + 4'({3'd0, p4}) + 4'({3'd0, p5}) +
                  4'({3'd0, p6}) + 4'({3'd0, p7}) + 4'({3'd0, p8}) + 4'({3'd0, p9});

        if (subpass == SUBPASS_FIRST)
        begin
            m1 = p2 & p4 & p6;
            m2 = p4 & p6 & p8;
        end
        else
        begin
            m1 = p2 & p4 & p8;
            m2 = p2 & p6 & p8;
        end

        del = p1 && (trans_cnt == 4'd1) && (nbr_cnt >= MIN_NEIGHBORS) &&
              (nbr_cnt <= MAX_NEIGHBORS) && !m1 && !m2;

        verdict.del  = del;
        verdict.keep = p1 & !del;
    end

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps
// Testbench for zhang_suen_thinning_pass_top. It streams binary frames with bursty pacing and
// output back-pressure, and checks every interior result against a local thinning predictor,
// or against a typed expectation in directed steps. Depends on zst_pkg and the block's RTL only.
module tb_top;
    import zst_pkg::*;

    localparam int MAX_DIM       = 1024;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int RANDOM_PIXELS = 1250;
    localparam int EXP_DEPTH     = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic pixel_out;
        logic removed;
        logic frame_last;
        logic any_removed;
    } thin_result_t;

    typedef enum logic [1:0] {STEP_PIXEL, STEP_WRITE, STEP_DRAIN} step_kind_t;
    typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

    typedef struct {
        step_kind_t            kind;
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] reg_value;
        int                    run;
        bit                    typed;
        thin_result_t          want;
    } step_t;

    // Pixel rows hold their pixels first-in at bit 0; a typed result belongs to the last pixel.
    step_t directed_plan [18] = '{
        '{STEP_PIXEL, '0, 11'h01B, 5, 1'b0, 4'b0000},
        '{STEP_DRAIN, '0, 11'h000, 0, 1'b0, 4'b0000},
        '{STEP_WRITE, CFG_SPARE, 11'h7FF, 0, 1'b0, 4'b0000},
        '{STEP_WRITE, CFG_IMAGE_WIDTH, 11'd3, 0, 1'b0, 4'b0000},
        '{STEP_PIXEL, '0, 11'h000, 1, 1'b0, 4'b0000},
        '{STEP_PIXEL, '0, 11'h0BE, 9, 1'b0, 4'b0000},
        '{STEP_DRAIN, '0, 11'h000, 0, 1'b0, 4'b0000},
        '{STEP_WRITE, CFG_IMAGE_HEIGHT, 11'd3, 0, 1'b0, 4'b0000},
        '{STEP_PIXEL, '0, 11'h003, 3, 1'b0, 4'b0000},
        '{STEP_DRAIN, '0, 11'h000, 0, 1'b0, 4'b0000},
        '{STEP_WRITE, CFG_IMAGE_WIDTH, 11'd0, 0, 1'b0, 4'b0000},
        '{STEP_PIXEL, '0, 11'h1B6, 9, 1'b1, 4'b1010},
        '{STEP_DRAIN, '0, 11'h000, 0, 1'b0, 4'b0000},
        '{STEP_WRITE, CFG_SUBPASS_SELECT, CFG_DATA_W'(SUBPASS_SECOND), 0, 1'b0, 4'b0000},
        '{STEP_PIXEL, '0, 11'h1B6, 9, 1'b1, 4'b0111},
        '{STEP_PIXEL, '0, 11'h1FF, 9, 1'b1, 4'b1010},
        '{STEP_PIXEL, '0, 11'h000, 9, 1'b1, 4'b0010},
        '{STEP_DRAIN, '0, 11'h000, 0, 1'b0, 4'b0000}
    };

    string field_names [4] = '{"any_removed", "frame_last", "removed", "pixel_out"};

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  cfg_write  = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  in_valid   = 1'b0;
    logic                  pixel_in   = 1'b0;
    logic                  out_stall  = 1'b0;
    logic                  in_stall;
    logic                  out_valid;
    logic                  pixel_out;
    logic                  removed;
    logic                  frame_last;
    logic                  any_removed;

    logic [CFG_DATA_W-1:0] width_reg   = DIM_RESET;
    logic [CFG_DATA_W-1:0] height_reg  = DIM_RESET;
    logic                  subpass_reg = SUBPASS_FIRST;
    bit                    line_above     [MAX_DIM];
    bit                    line_two_above [MAX_DIM];
    logic [8:0]            window_bits   = '0;
    int                    col_pos       = 0;
    int                    row_pos       = 0;
    bit                    frame_removal = 1'b0;

    thin_result_t expected_fifo [EXP_DEPTH];
    int exp_wr        = 0;
    int exp_rd        = 0;
    int mismatches    = 0;
    int results_seen  = 0;
    int frames_seen   = 0;
    int removals_seen = 0;
    int pixels_sent   = 0;
    int burst_left    = 0;
    int cycles        = 0;
    int stall_left    = 0;
    stall_mode_t stall_mode = STALL_NONE;

    always #5 clk = ~clk;

    zhang_suen_thinning_pass_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel_in    (pixel_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_out   (pixel_out),
        .removed     (removed),
        .frame_last  (frame_last),
        .any_removed (any_removed)
    );

    function automatic int pending();
        return exp_wr - exp_rd;
    endfunction

    function automatic void store_expected(input thin_result_t res);
        expected_fifo[exp_wr % EXP_DEPTH] = res;
        exp_wr++;
    endfunction

    function automatic thin_result_t take_expected();
        thin_result_t res;
        res = expected_fifo[exp_rd % EXP_DEPTH];
        exp_rd++;
        return res;
    endfunction

    function automatic int clamp_dim(input logic [CFG_DATA_W-1:0] raw);
        if (raw < DIM_MIN)
            return DIM_MIN;
        if (raw > MAX_DIM)
            return MAX_DIM;
        return raw;
    endfunction

    // Advances the thinning state by one pixel; returns 1 when an interior result is due.
    function automatic bit predict_pixel(input logic pix, output thin_result_t res);
        int w;
        int h;
        int idx;
        int trans;
        int count;
        logic above;
        logic two;
        logic m1;
        logic m2;
        logic del;
        logic [7:0] ring;
        bit row_end;
        bit frame_end;
        bit emit;
        w = clamp_dim(width_reg);
        h = clamp_dim(height_reg);
        idx = col_pos % MAX_DIM;
        above = line_above[idx];
        two = line_two_above[idx];
        row_end = col_pos >= w - 1;
        frame_end = row_end && row_pos >= h - 1;
        window_bits = {pix, window_bits[8:7], above, window_bits[5:4], two, window_bits[2:1]};
        line_two_above[idx] = above;
        line_above[idx] = pix;
        emit = row_pos >= 2 && col_pos >= 2;
        res = '0;
        if (emit)
        begin
            // The neighbors in ring order, north first and then clockwise.
            ring = {window_bits[0], window_bits[3], window_bits[6], window_bits[7],
                    window_bits[8], window_bits[5], window_bits[2], window_bits[1]};
            trans = 0;
            for (int i = 0; i < 8; i++)
            begin
                if (!ring[i] && ring[(i + 1) % 8])
                    trans++;
            end
            count = $countones(ring);
            if (subpass_reg == SUBPASS_FIRST)
            begin
                m1 = ring[0] & ring[2] & ring[4];
                m2 = ring[2] & ring[4] & ring[6];
            end
            else
            begin
                m1 = ring[0] & ring[2] & ring[6];
                m2 = ring[0] & ring[4] & ring[6];
            end
            del = window_bits[4] && trans == 1 && count >= int'(MIN_NEIGHBORS)
                  && count <= int'(MAX_NEIGHBORS) && !m1 && !m2;
            frame_removal |= del;
            res.pixel_out = window_bits[4] & ~del;
            res.removed = del;
            res.frame_last = frame_end;
            res.any_removed = frame_end & frame_removal;
        end
        if (row_end)
        begin
            col_pos = 0;
            if (frame_end)
            begin
                row_pos = 0;
                frame_removal = 1'b0;
            end
            else
                row_pos++;
        end
        else
            col_pos++;
        return emit;
    endfunction

    task automatic pace();
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 40);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    task automatic send_pixel(input logic pix, input bit typed, input thin_result_t want);
        thin_result_t res;
        bit emit;
        pace();
        in_valid <= 1'b1;
        pixel_in <= pix;
        do
            @(posedge clk);
        while (in_stall);
        emit = predict_pixel(pix, res);
        if (typed)
            store_expected(want);
        else if (emit)
            store_expected(res);
        pixels_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[CFG_DATA_W-1:0];
        @(posedge clk);
        case (idx)
            CFG_IMAGE_WIDTH:    width_reg = value[CFG_DATA_W-1:0];
            CFG_IMAGE_HEIGHT:   height_reg = value[CFG_DATA_W-1:0];
            CFG_SUBPASS_SELECT: subpass_reg = value[0];
            default: ;
        endcase
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_frame(input int w, input int h);
        bit blob;
        int dens;
        int x0;
        int x1;
        int y0;
        int y1;
        logic pix;
        blob = $urandom_range(0, 9) < 7;
        dens = $urandom_range(0, 8);
        x0 = $urandom_range(0, w - 1);
        x1 = $urandom_range(x0, w - 1);
        y0 = $urandom_range(0, h - 1);
        y1 = $urandom_range(y0, h - 1);
        for (int y = 0; y < h; y++)
        begin
            for (int x = 0; x < w; x++)
            begin
                if (blob)
                    pix = (x >= x0 && x <= x1 && y >= y0 && y <= y1) ^ ($urandom_range(0, 15) == 0);
                else
                    pix = $urandom_range(0, 7) < dens;
                send_pixel(pix, 1'b0, '0);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_left = $urandom_range(20, 120);
        end
        stall_left--;
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= $urandom_range(0, 3) == 0;
            STALL_HEAVY: out_stall <= $urandom_range(0, 3) != 0;
            default:     out_stall <= stall_left[2];
        endcase
    end

    always @(posedge clk)
    begin
        thin_result_t got;
        thin_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {pixel_out, removed, frame_last, any_removed};
            if (pending() == 0)
            begin
                $display("%0t: unexpected beat, expected none, got %b", $time, got);
                mismatches++;
            end
            else
            begin
                want = take_expected();
                for (int f = 0; f < 4; f++)
                begin
                    if (got[f] !== want[f])
                    begin
                        $display("%0t: %s expected %b got %b", $time, field_names[f], want[f],
                                 got[f]);
                        mismatches++;
                    end
                end
            end
            results_seen++;
            frames_seen += frame_last;
            removals_seen += removed;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles with %0d results pending", cycles, pending());
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        int phase;
        int pick;
        int w_raw;
        int h_raw;
        int frames;
        int random_pixels;
        int start_count;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < $size(directed_plan); i++)
        begin
            case (directed_plan[i].kind)
                STEP_PIXEL:
                    for (int k = 0; k < directed_plan[i].run; k++)
                        send_pixel(directed_plan[i].reg_value[k],
                                   directed_plan[i].typed && k == directed_plan[i].run - 1,
                                   directed_plan[i].want);
                STEP_WRITE:
                    write_reg(directed_plan[i].reg_index, directed_plan[i].reg_value);
                default:
                    drain();
            endcase
        end

        phase = 0;
        random_pixels = 0;
        while (random_pixels < RANDOM_PIXELS)
        begin
            start_count = pixels_sent;
            frames = $urandom_range(1, 3);
            pick = $urandom_range(0, 9);
            w_raw = (pick < 8) ? $urandom_range(3, 12)
                  : (pick == 8) ? $urandom_range(0, 2) : $urandom_range(13, 40);
            pick = $urandom_range(0, 9);
            h_raw = (pick < 8) ? $urandom_range(3, 8)
                  : (pick == 8) ? $urandom_range(0, 2) : $urandom_range(9, 16);
            write_reg(CFG_IMAGE_WIDTH, w_raw);
            write_reg(CFG_IMAGE_HEIGHT, h_raw);
            write_reg(CFG_SUBPASS_SELECT, $urandom_range(0, 1));
            repeat (frames) run_frame(clamp_dim(w_raw), clamp_dim(h_raw));
            drain();
            random_pixels += pixels_sent - start_count;
            phase++;
        end

        drain();
        $display("covered %0d pixels over %0d settings, %0d results checked,",
                 pixels_sent, phase + 4, results_seen);
        $display("with %0d frames completed and %0d pixels removed", frames_seen, removals_seen);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
